// ----- hw/rtl/assert_macros.svh -----
// Assertion macros for the 4x4 matrix multiplier RTL.
// Expects clk and rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHECK_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/m4m_pkg.sv -----
// Package for the 4x4 matrix multiplier: transaction types, modes, states and constants.
// No dependencies.
`default_nettype none

package m4m_pkg;

    localparam int DATA_W    = 32;
    localparam int FRAC_BITS = 16;

    localparam logic signed [DATA_W-1:0] ONE_Q   = 32'sh0001_0000;
    localparam logic signed [DATA_W-1:0] SAT_MAX = 32'sh7fff_ffff;
    localparam logic signed [DATA_W-1:0] SAT_MIN = 32'sh8000_0000;

    localparam logic [1:0] MODE_LOAD_LEFT  = 2'd0;
    localparam logic [1:0] MODE_LOAD_RIGHT = 2'd1;
    localparam logic [1:0] MODE_MULTIPLY   = 2'd2;

    typedef struct packed {
        logic [1:0]               mode;
        logic [1:0]               row;
        logic [1:0]               col;
        logic signed [DATA_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic [1:0]               out_row;
        logic [1:0]               out_col;
        logic signed [DATA_W-1:0] product;
        logic                     last;
    } out_item_t;

    typedef struct packed {
        logic issue;
        logic first;
        logic last;
    } mac_ctl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_WAIT,
        ST_EMIT
    } m4m_state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/m4m_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module m4m_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/m4m_store.sv -----
// Matrix operand store: RAM plus per-entry written flags, unwritten entries read as identity.
// Depends on m4m_pkg and m4m_ram.
`default_nettype none

module m4m_store import m4m_pkg::*; #(
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic signed [DATA_W-1:0] wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    input  wire logic                     rd_diag,
    output logic signed [DATA_W-1:0]      rd_data
);

    logic [DEPTH-1:0]  valid_reg;
    logic              rd_valid_reg;
    logic              rd_diag_reg;
    logic [DATA_W-1:0] ram_q;

    m4m_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (ram_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
            rd_diag_reg  <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
                rd_diag_reg  <= rd_diag;
            end
        end
    end

    always_comb
    begin
        if (rd_valid_reg)
        begin
            rd_data = $signed(ram_q);
        end
        else if (rd_diag_reg)
        begin
            rd_data = ONE_Q;
        end
        else
        begin
            rd_data = '0;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/m4m_mac.sv -----
// Multiply-accumulate datapath: one Q16.16 product per cycle, exact sum, floor shift, saturate.
// Depends on m4m_pkg.
`default_nettype none

module m4m_mac import m4m_pkg::*; #(
    parameter int DIM = 4
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire mac_ctl_t                 ctl,
    input  wire logic signed [DATA_W-1:0] a,
    input  wire logic signed [DATA_W-1:0] b,
    output logic                          done,
    output logic signed [DATA_W-1:0]      sat
);

    localparam int PROD_W = 2 * DATA_W;
    localparam int ACC_W  = PROD_W + 1 + $clog2(DIM);

    mac_ctl_t                  ctl_d1_reg;
    mac_ctl_t                  ctl_d2_reg;
    logic                      done_reg;
    logic signed [PROD_W-1:0]  product_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [ACC_W-1:0]   acc_next;
    logic signed [ACC_W-1:0]   product_ext;
    logic signed [ACC_W-1:0]   shifted;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_d1_reg <= '0;
            ctl_d2_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            ctl_d1_reg <= ctl;
            ctl_d2_reg <= ctl_d1_reg;
            done_reg   <= ctl_d2_reg.issue && ctl_d2_reg.last;
        end
    end

    assign product_ext = $signed({{(ACC_W-PROD_W){product_reg[PROD_W-1]}}, product_reg});

    always_comb
    begin
        if (ctl_d2_reg.first)
        begin
            acc_next = product_ext;
        end
        else
        begin
            acc_next = acc_reg + product_ext;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl_d1_reg.issue)
        begin
            product_reg <= a * b;
        end
        if (ctl_d2_reg.issue)
        begin
            acc_reg <= acc_next;
        end
    end

    assign shifted = acc_reg >>> FRAC_BITS;

    always_comb
    begin
        if ((&shifted[ACC_W-1:DATA_W-1]) || !(|shifted[ACC_W-1:DATA_W-1]))
        begin
            sat = shifted[DATA_W-1:0];
        end
        else if (shifted[ACC_W-1])
        begin
            sat = SAT_MIN;
        end
        else
        begin
            sat = SAT_MAX;
        end
    end

    assign done = done_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/matrix4x4_multiply.sv -----
// Sequence: a load transaction is written while idle. A multiply transaction emits DIM*DIM results,
// one after another, each after DIM operand reads from both stores, then the multiply and
// accumulate stages.
// Throughput: one transaction at a time; a full output register holds the sequencer.
// Reset: both operand stores read as identity until written; control and the output valid flag clear.
`default_nettype none
`include "assert_macros.svh"

module matrix4x4_multiply import m4m_pkg::*; #(
    parameter int DIM = 4
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      item_valid,
    output logic           item_stall,
    input  wire in_item_t  item,
    output logic           result_valid,
    input  wire logic      result_stall,
    output out_item_t      result
);

    localparam int IDX_W  = $clog2(DIM);
    localparam int DEPTH  = DIM * DIM;
    localparam int ADDR_W = $clog2(DEPTH);

    m4m_state_t               state_reg;
    m4m_state_t               state_next;
    logic [IDX_W-1:0]         r_reg;
    logic [IDX_W-1:0]         r_next;
    logic [IDX_W-1:0]         c_reg;
    logic [IDX_W-1:0]         c_next;
    logic [IDX_W-1:0]         k_reg;
    logic [IDX_W-1:0]         k_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    out_item_t                out_item_reg;
    out_item_t                out_item_next;

    mac_ctl_t                 mac_ctl;
    logic                     mac_done;
    logic signed [DATA_W-1:0] mac_sat;
    logic signed [DATA_W-1:0] left_q;
    logic signed [DATA_W-1:0] right_q;

    logic                     wr_left;
    logic                     wr_right;
    logic                     load_in_range;
    logic [ADDR_W-1:0]        wr_addr;
    logic [ADDR_W-1:0]        left_rd_addr;
    logic [ADDR_W-1:0]        right_rd_addr;
    logic                     last_elem;

    assign load_in_range = (32'(item.row) < DIM) && (32'(item.col) < DIM);
    assign wr_addr       = ADDR_W'(32'(item.row) * DIM + 32'(item.col));
    assign left_rd_addr  = ADDR_W'(32'(r_reg) * DIM + 32'(k_reg));
    assign right_rd_addr = ADDR_W'(32'(k_reg) * DIM + 32'(c_reg));
    assign last_elem     = (r_reg == IDX_W'(DIM - 1)) && (c_reg == IDX_W'(DIM - 1));

    m4m_store #(
        .DEPTH (DEPTH)
    ) u_left (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_left),
        .wr_addr (wr_addr),
        .wr_data (item.value),
        .rd_en   (mac_ctl.issue),
        .rd_addr (left_rd_addr),
        .rd_diag (r_reg == k_reg),
        .rd_data (left_q)
    );

    m4m_store #(
        .DEPTH (DEPTH)
    ) u_right (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_right),
        .wr_addr (wr_addr),
        .wr_data (item.value),
        .rd_en   (mac_ctl.issue),
        .rd_addr (right_rd_addr),
        .rd_diag (k_reg == c_reg),
        .rd_data (right_q)
    );

    m4m_mac #(
        .DIM (DIM)
    ) u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mac_ctl),
        .a     (left_q),
        .b     (right_q),
        .done  (mac_done),
        .sat   (mac_sat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            r_reg         <= '0;
            c_reg         <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            r_reg         <= r_next;
            c_reg         <= c_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        r_next         = r_reg;
        c_next         = c_reg;
        k_next         = k_reg;
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        item_stall     = 1'b1;
        wr_left        = 1'b0;
        wr_right       = 1'b0;
        mac_ctl        = '0;

        // drop the result once taken
        if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                item_stall = 1'b0;
                if (item_valid)
                begin
                    case (item.mode)
                        MODE_LOAD_LEFT:
                        begin
                            wr_left = load_in_range;
                        end
                        MODE_LOAD_RIGHT:
                        begin
                            wr_right = load_in_range;
                        end
                        MODE_MULTIPLY:
                        begin
                            r_next     = '0;
                            c_next     = '0;
                            k_next     = '0;
                            state_next = ST_RUN;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_RUN:
            begin
                mac_ctl.issue = 1'b1;
                mac_ctl.first = (k_reg == '0);
                mac_ctl.last  = (k_reg == IDX_W'(DIM - 1));
                if (mac_ctl.last)
                begin
                    k_next     = '0;
                    state_next = ST_WAIT;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            ST_WAIT:
            begin
                if (mac_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || !result_stall)
                begin
                    out_valid_next        = 1'b1;
                    out_item_next.out_row = 2'(r_reg);
                    out_item_next.out_col = 2'(c_reg);
                    out_item_next.product = mac_sat;
                    out_item_next.last    = last_elem;
                    if (last_elem)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        // advance row-major
                        state_next = ST_RUN;
                        if (c_reg == IDX_W'(DIM - 1))
                        begin
                            c_next = '0;
                            r_next = r_reg + 1'b1;
                        end
                        else
                        begin
                            c_next = c_reg + 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign result_valid = out_valid_reg;
    assign result       = out_item_reg;

    `CHECK_IMPL(a_done_in_wait, mac_done, state_reg == ST_WAIT, "accumulator done outside wait")
    `CHECK_NEXT(a_done_to_emit, mac_done, state_reg == ST_EMIT, "done did not lead to emit")
    `CHECK_NEXT(a_emit_fills_out, (state_reg == ST_EMIT) && (!result_valid || !result_stall), result_valid, "emit did not fill output")
    `CHECK_IMPL(a_k_in_range, state_reg == ST_RUN, k_reg <= IDX_W'(DIM - 1), "inner index out of range")

endmodule

`default_nettype wire

// ----- verif/matrix4x4_multiply_tb.sv -----
// Self-checking testbench for matrix4x4_multiply: element loads, products, saturation.
// Depends on m4m_pkg and matrix4x4_multiply; predicts every product element on its own.
`default_nettype none

module matrix4x4_multiply_tb;
    import m4m_pkg::*;

    localparam int          DIM            = 4;
    localparam int          CLK_PERIOD     = 12;
    localparam int          LONG_HOLD      = 200;
    localparam int          TAIL_CYCLES    = 150;
    localparam int          TIMEOUT_CYCLES = 400000;
    localparam int          ITEM_W         = $bits(in_item_t);
    localparam logic [1:0]  MODE_UNUSED    = 2'd3;

    logic      clk;
    logic      rst_n;
    logic      item_valid;
    logic      item_stall;
    in_item_t  item;
    logic      result_valid;
    logic      result_stall;
    out_item_t result;

    logic signed [DATA_W-1:0] left_store  [DIM*DIM];
    logic signed [DATA_W-1:0] right_store [DIM*DIM];
    out_item_t                expected_products [$];
    int                       mismatch_count;
    bit                       quiet_phase;
    bit                       hold_pending;

    matrix4x4_multiply #(.DIM(DIM)) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("matrix4x4_multiply verification failed");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        $display("%0t mismatch %s: got %h, expected %h", $time, what, got, want);
        mismatch_count++;
    endtask

    function automatic logic signed [DATA_W-1:0] product_element(input int r, input int c);
        logic signed [65:0] acc;
        logic signed [65:0] scaled;
        int                 k;
        acc = '0;
        for (k = 0; k < DIM; k++)
            acc = acc + 66'(left_store[r*DIM+k]) * 66'(right_store[k*DIM+c]);
        scaled = acc >>> FRAC_BITS;
        if (scaled > 66'(SAT_MAX))
            return SAT_MAX;
        if (scaled < 66'(SAT_MIN))
            return SAT_MIN;
        return scaled[DATA_W-1:0];
    endfunction

    function automatic void reset_stores();
        int i;
        for (i = 0; i < DIM*DIM; i++)
        begin
            left_store[i]  = (i / DIM == i % DIM) ? ONE_Q : '0;
            right_store[i] = (i / DIM == i % DIM) ? ONE_Q : '0;
        end
    endfunction

    function automatic void apply_transaction(input in_item_t it);
        out_item_t e;
        int        r;
        int        c;
        case (it.mode)
            MODE_LOAD_LEFT:
                if (it.row < DIM && it.col < DIM)
                    left_store[it.row*DIM+it.col] = it.value;
            MODE_LOAD_RIGHT:
                if (it.row < DIM && it.col < DIM)
                    right_store[it.row*DIM+it.col] = it.value;
            MODE_MULTIPLY:
                for (r = 0; r < DIM; r++)
                    for (c = 0; c < DIM; c++)
                    begin
                        e.out_row = r[1:0];
                        e.out_col = c[1:0];
                        e.product = product_element(r, c);
                        e.last    = (r == DIM - 1) && (c == DIM - 1);
                        expected_products.push_back(e);
                    end
            default:
                ;
        endcase
    endfunction

    task automatic send_item(input in_item_t it);
        if (!quiet_phase && $urandom_range(0, 3) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        do
            @(posedge clk);
        while (item_stall);
        apply_transaction(it);
    endtask

    task automatic send_load(input logic [1:0] mode, input int r, input int c,
                             input logic signed [DATA_W-1:0] value);
        in_item_t it;
        it.mode  = mode;
        it.row   = r[1:0];
        it.col   = c[1:0];
        it.value = value;
        send_item(it);
    endtask

    task automatic send_multiply();
        in_item_t it;
        it       = in_item_t'(ITEM_W'({$urandom, $urandom}));
        it.mode  = MODE_MULTIPLY;
        send_item(it);
    endtask

    // check each result transaction against the oldest prediction
    always @(posedge clk)
    begin : check_results
        out_item_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_products.size() == 0)
                report_mismatch("unexpected result", result.product, '0);
            else
            begin
                want = expected_products.pop_front();
                if (result.out_row !== want.out_row)
                    report_mismatch("out_row", DATA_W'(result.out_row),
                                    DATA_W'(want.out_row));
                if (result.out_col !== want.out_col)
                    report_mismatch("out_col", DATA_W'(result.out_col),
                                    DATA_W'(want.out_col));
                if (result.product !== want.product)
                    report_mismatch("product", result.product, want.product);
                if (result.last !== want.last)
                    report_mismatch("last", DATA_W'(result.last), DATA_W'(want.last));
            end
        end
    end

    initial
    begin
        result_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                result_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                result_stall <= 1'b0;
            end
            else if (rst_n && !quiet_phase && $urandom_range(0, 3) == 0)
            begin
                result_stall <= 1'b1;
                repeat ($urandom_range(1, 5)) @(posedge clk);
                result_stall <= 1'b0;
            end
        end
    end

    task automatic test_identity_after_reset();
        send_multiply();
    endtask

    task automatic test_unused_mode();
        send_load(MODE_UNUSED, 0, 0, SAT_MAX);
        send_load(MODE_UNUSED, 3, 3, SAT_MIN);
        send_multiply();
    endtask

    task automatic test_saturation_and_floor();
        int k;
        for (k = 0; k < DIM; k++)
            send_load(MODE_LOAD_LEFT, 0, k, SAT_MAX);
        for (k = 0; k < DIM; k++)
            send_load(MODE_LOAD_RIGHT, k, 0, SAT_MAX);
        for (k = 0; k < DIM; k++)
            send_load(MODE_LOAD_RIGHT, k, 1, SAT_MIN);
        // minus one LSB times one LSB must round down, not towards zero
        send_load(MODE_LOAD_LEFT, 1, 0, -32'sd1);
        send_load(MODE_LOAD_RIGHT, 0, 2, 32'sd1);
        send_multiply();
    endtask

    task automatic test_backpressure();
        hold_pending = 1'b1;
        send_multiply();
        send_load(MODE_LOAD_LEFT, 2, 3, -ONE_Q);
        send_multiply();
        send_load(MODE_LOAD_RIGHT, 3, 2, ONE_Q);
        send_multiply();
    endtask

    task automatic test_random_traffic(input int count);
        in_item_t                 it;
        logic signed [DATA_W-1:0] picks [7];
        int                       sent;
        int                       roll;
        picks = '{SAT_MAX, SAT_MIN, '0, ONE_Q, -ONE_Q, 32'sd1, -32'sd1};
        sent  = 0;
        while (sent < count)
        begin
            it   = in_item_t'(ITEM_W'({$urandom, $urandom}));
            roll = $urandom_range(0, 99);
            case ($urandom_range(0, 2))
                0:       it.value = $urandom;
                1:       it.value = $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
                default: it.value = picks[$urandom_range(0, 6)];
            endcase
            if (roll < 6)
                it.mode = MODE_UNUSED;
            else if (roll < 18)
                it.mode = MODE_MULTIPLY;
            else
                it.mode = (roll < 59) ? MODE_LOAD_LEFT : MODE_LOAD_RIGHT;
            send_item(it);
            if (it.mode != MODE_UNUSED)
                sent++;
        end
    endtask

    task automatic test_steady_tail();
        quiet_phase = 1'b1;
        test_random_traffic(40);
    endtask

    initial
    begin
        mismatch_count = 0;
        quiet_phase    = 1'b0;
        hold_pending   = 1'b0;
        reset_stores();
        rst_n      <= 1'b0;
        item_valid <= 1'b0;
        item       <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        test_identity_after_reset();
        test_unused_mode();
        test_saturation_and_floor();
        test_backpressure();
        test_random_traffic(130);
        test_steady_tail();

        item_valid <= 1'b0;
        while (expected_products.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("matrix4x4_multiply verification clean");
        else
            $display("matrix4x4_multiply verification failed");
        $finish;
    end

endmodule

`default_nettype wire

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/m4m_pkg.sv
hw/rtl/m4m_ram.sv
hw/rtl/m4m_store.sv
hw/rtl/m4m_mac.sv
hw/rtl/matrix4x4_multiply.sv
verif/matrix4x4_multiply_tb.sv
